// ===== rtl/vertex_transform_4x4_macros.svh =====
// Assertion macros for the vertex transform block
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH
`ifndef SYNTHESIS
`define VT4_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vt4 check failed");
`define VT4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vt4 check failed");
`else
`define VT4_ASSERT_IMPL(label, ante, cons)
`define VT4_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/vt4_pkg.sv =====
`default_nettype none
package vt4_pkg;

	localparam int VEC_W       = 32;
	localparam int COEFF_W     = 16;
	localparam int CFG_W       = 64;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_COLS    = 4;

	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] in_x;
		logic signed [VEC_W-1:0] in_y;
		logic signed [VEC_W-1:0] in_z;
		logic signed [VEC_W-1:0] in_w;
	} vec_in_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] out_x;
		logic signed [VEC_W-1:0] out_y;
		logic signed [VEC_W-1:0] out_z;
		logic signed [VEC_W-1:0] out_w;
		logic                    clamped;
	} vec_out_t;

	function automatic logic signed [VEC_W-1:0] vec_comp(vec_in_t v, logic [1:0] col);
		logic signed [VEC_W-1:0] r;
		unique case (col)
			2'd0: r = v.in_x;
			2'd1: r = v.in_y;
			2'd2: r = v.in_z;
			default: r = v.in_w;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vt4_cell.sv =====
`default_nettype none
module vt4_cell #(
	parameter int COEFF_WIDTH = vt4_pkg::COEFF_W,
	parameter int COL         = 0
) (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic [vt4_pkg::NUM_ROWS-1:0][COEFF_WIDTH-1:0]         coef,
	input  wire logic                                                  in_valid,
	output logic                                                       in_stall,
	input  wire vt4_pkg::vec_in_t                                      vec_in,
	input  wire logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH+1:0] acc_in,
	input  wire logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH-1:0] prod_in,
	output logic                                                       out_valid,
	input  wire logic                                                  out_stall,
	output vt4_pkg::vec_in_t                                           vec_out,
	output logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH+1:0] acc_out,
	output logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH-1:0] prod_out
);
	localparam int PW = vt4_pkg::VEC_W + COEFF_WIDTH;
	localparam int AW = PW + 2;

	logic                                valid_q;
	vt4_pkg::vec_in_t                    vec_q;
	logic [vt4_pkg::NUM_ROWS-1:0][AW-1:0] acc_q;
	logic [vt4_pkg::NUM_ROWS-1:0][PW-1:0] prod_q;
	logic signed [vt4_pkg::VEC_W-1:0]    comp;
	logic [vt4_pkg::NUM_ROWS-1:0][AW-1:0] acc_d;
	logic [vt4_pkg::NUM_ROWS-1:0][PW-1:0] prod_d;
	logic                                take;

	assign comp     = vt4_pkg::vec_comp(vec_in, 2'(COL));
	assign in_stall = valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	always_comb begin
		for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
			prod_d[r] = PW'($signed(coef[r]) * comp);
			acc_d[r]  = AW'($signed(acc_in[r]) + $signed(AW'($signed(prod_in[r]))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			vec_q  <= vec_in;
			acc_q  <= acc_d;
			prod_q <= prod_d;
		end
	end

	assign out_valid = valid_q;
	assign vec_out   = vec_q;
	assign acc_out   = acc_q;
	assign prod_out  = prod_q;
endmodule
`default_nettype wire

// ===== rtl/vt4_round.sv =====
`default_nettype none
module vt4_round #(
	parameter int COEFF_WIDTH = vt4_pkg::COEFF_W
) (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  in_valid,
	output logic                                                       in_stall,
	input  wire logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH+1:0] acc_in,
	input  wire logic [vt4_pkg::NUM_ROWS-1:0][vt4_pkg::VEC_W+COEFF_WIDTH-1:0] prod_in,
	output logic                                                       out_valid,
	input  wire logic                                                  out_stall,
	output vt4_pkg::vec_out_t                                          res
);
	localparam int VW   = vt4_pkg::VEC_W;
	localparam int PW   = VW + COEFF_WIDTH;
	localparam int AW   = PW + 2;
	localparam int FRAC = COEFF_WIDTH - 4;
	localparam int SW   = AW - FRAC;
	localparam logic [AW-1:0] HALF = AW'(1) << (FRAC - 1);

	logic                                 valid_q;
	vt4_pkg::vec_out_t                    res_q;
	vt4_pkg::vec_out_t                    res_d;
	logic signed [AW-1:0]                 sum   [vt4_pkg::NUM_ROWS];
	logic signed [SW-1:0]                 sh    [vt4_pkg::NUM_ROWS];
	logic [vt4_pkg::NUM_ROWS-1:0]         fits;
	logic [vt4_pkg::NUM_ROWS-1:0][VW-1:0] val;

	assign in_stall = valid_q && out_stall;

	always_comb begin
		for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
			sum[r]  = $signed(acc_in[r]) + $signed(AW'($signed(prod_in[r])))
				+ $signed(HALF);
			sh[r]   = sum[r][AW-1:FRAC];
			fits[r] = (&sh[r][SW-1:VW-1]) || !(|sh[r][SW-1:VW-1]);
			if (fits[r]) begin
				val[r] = sh[r][VW-1:0];
			end else if (sh[r][SW-1]) begin
				val[r] = {1'b1, {(VW-1){1'b0}}};
			end else begin
				val[r] = {1'b0, {(VW-1){1'b1}}};
			end
		end
		res_d.out_x   = val[0];
		res_d.out_y   = val[1];
		res_d.out_z   = val[2];
		res_d.out_w   = val[3];
		res_d.clamped = !(&fits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

// ===== rtl/vertex_transform_4x4.sv =====
// An accepted request passes through the four column cells and then the rounding stage.
// Throughput: one vertex per cycle unless out_stall holds it; each column cell takes one
// multiply-accumulate step per cycle, and the rounding stage drains one per cycle.
// Reset: arst_n clears all valid flags and loads the identity matrix into the
// row registers.
`default_nettype none
`include "vertex_transform_4x4_macros.svh"
module vertex_transform_4x4 #(
	parameter int COEFF_WIDTH = vt4_pkg::COEFF_W
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire vt4_pkg::vec_in_t          in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output vt4_pkg::vec_out_t              out_data,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_idx,
	input  wire logic [vt4_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int NR = vt4_pkg::NUM_ROWS;
	localparam int NC = vt4_pkg::NUM_COLS;
	localparam int PW = vt4_pkg::VEC_W + COEFF_WIDTH;
	localparam int AW = PW + 2;
	localparam logic [vt4_pkg::CFG_W-1:0] COEF_ONE = vt4_pkg::CFG_W'(1) << (COEFF_WIDTH - 4);

	logic [vt4_pkg::CFG_W-1:0]      row_q    [NR];
	logic [NR-1:0][COEFF_WIDTH-1:0] coef_col [NC];

	logic                     valid_c [NC+1];
	logic                     stall_c [NC+1];
	vt4_pkg::vec_in_t         vec_c   [NC+1];
	logic [NR-1:0][AW-1:0]    acc_c   [NC+1];
	logic [NR-1:0][PW-1:0]    prod_c  [NC+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NR; r++) begin
				row_q[r] <= COEF_ONE << (r * COEFF_WIDTH);
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				vt4_pkg::REG_ROW0: row_q[0] <= cfg_wdata;
				vt4_pkg::REG_ROW1: row_q[1] <= cfg_wdata;
				vt4_pkg::REG_ROW2: row_q[2] <= cfg_wdata;
				vt4_pkg::REG_ROW3: row_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			for (int r = 0; r < NR; r++) begin
				coef_col[c][r] = row_q[r][c*COEFF_WIDTH +: COEFF_WIDTH];
			end
		end
	end

	assign valid_c[0] = in_valid;
	assign in_stall   = stall_c[0];
	assign vec_c[0]   = in_data;
	assign acc_c[0]   = '0;
	assign prod_c[0]  = '0;

	for (genvar c = 0; c < NC; c++) begin : g_cell
		vt4_cell #(
			.COEFF_WIDTH (COEFF_WIDTH),
			.COL         (c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.coef      (coef_col[c]),
			.in_valid  (valid_c[c]),
			.in_stall  (stall_c[c]),
			.vec_in    (vec_c[c]),
			.acc_in    (acc_c[c]),
			.prod_in   (prod_c[c]),
			.out_valid (valid_c[c+1]),
			.out_stall (stall_c[c+1]),
			.vec_out   (vec_c[c+1]),
			.acc_out   (acc_c[c+1]),
			.prod_out  (prod_c[c+1])
		);
	end

	vt4_round #(
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[NC]),
		.in_stall  (stall_c[NC]),
		.acc_in    (acc_c[NC]),
		.prod_in   (prod_c[NC]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (out_data)
	);

	`VT4_ASSERT_NEXT(a_enter_cell, in_valid && !in_stall, valid_c[1])
	`VT4_ASSERT_IMPL(a_stall_origin, in_stall, out_valid && out_stall)
	`VT4_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(valid_c[NC]))
endmodule
`default_nettype wire
